>>> sv/iva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inactivity vibration alert: shared definitions
// Types, register codes, reset values and ramp constants used by the block.
// ----------------------------------------------------------------------------
package iva_pkg;

    localparam int DEF_WINDOW_LEN  = 4;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int TIME_W          = 32;
    localparam int QUEUE_DEPTH     = 2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MOTION_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_ONE_G              = 2'd1;
    localparam logic [1:0] REG_STATIONARY_TIME_MS = 2'd2;
    localparam logic [1:0] REG_RAMP_FLOOR         = 2'd3;

    localparam logic [15:0] RST_MOTION_THRESHOLD   = 16'd328;
    localparam logic [15:0] RST_ONE_G              = 16'd8192;
    localparam logic [31:0] RST_STATIONARY_TIME_MS = 32'd10000;
    localparam logic [7:0]  RST_RAMP_FLOOR         = 8'd40;

    // Ramp phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_UP   = 2'd1;
    localparam logic [1:0] PH_DOWN = 2'd2;

    localparam logic [7:0] RAMP_TOP  = 8'd255;
    localparam logic [7:0] RAMP_STEP = 8'd5;
    // Number of 10 ms ticks after which the ramp level reaches the top.
    localparam int         UP_TICKS  = 51;
    // floor(t / 10) equals (t * RECIP_10) >> RECIP_SHIFT for every 32-bit t.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam int OUT_BITS = 10;
    localparam int OUT_W    = 16;

    typedef struct packed {
        logic [15:0] motion_threshold;
        logic [15:0] one_g;
        logic [31:0] stationary_time_ms;
        logic [7:0]  ramp_floor;
    } t_cfg;

endpackage
`default_nettype wire

>>> sv/iva_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inactivity vibration alert: magnitude queue
// Short register queue carrying magnitude and timestamp from front to back.
// ----------------------------------------------------------------------------
module iva_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             n_do_push;
    logic             n_do_pop;

    assign o_full    = (r_cnt == CNT_W'(DEPTH));
    assign o_valid   = (r_cnt != '0);
    assign o_data    = r_mem[r_rd];
    assign n_do_push = i_push && !o_full;
    assign n_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (n_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (n_do_push && !n_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (n_do_pop && !n_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/iva_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inactivity vibration alert: front end
// Accepts a sample, sums the three squares and takes the integer square root
// one result bit per cycle, then queues magnitude and timestamp.
// ----------------------------------------------------------------------------
module iva_front #(
    parameter int SAMPLE_BITS = iva_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0]                 i_accel_x,
    input  wire logic [SAMPLE_BITS-1:0]                 i_accel_y,
    input  wire logic [SAMPLE_BITS-1:0]                 i_accel_z,
    input  wire logic [iva_pkg::TIME_W-1:0]             i_time_ms,
    output logic                                        o_push,
    output logic [iva_pkg::TIME_W+SAMPLE_BITS-1:0]      o_item,
    input  wire logic                                   i_full
);
    import iva_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int SQ_W  = 2 * S;
    localparam int CNT_W = $clog2(S);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SQ   = 2'd1;
    localparam logic [1:0] F_RT   = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]        r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [S-1:0]      r_smp [3];
    logic [TIME_W-1:0] r_time;
    logic [SQ_W-1:0]   r_acc;
    logic [S-1:0]      r_root;
    logic [S:0]        r_rem;

    logic [SQ_W-1:0]   n_sq;
    logic [S+2:0]      n_part;
    logic [S+2:0]      n_trial;
    logic              n_ge;

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH);
    assign o_item  = {r_time, r_root};

    always_comb begin
        n_sq    = SQ_W'($signed(r_smp[r_cnt[1:0]]) * $signed(r_smp[r_cnt[1:0]]));
        // Bring down the next two radicand bits and try appending a one to the root.
        n_part  = {r_rem, r_acc[SQ_W-1 -: 2]};
        n_trial = (S+3)'({r_root, 2'b01});
        n_ge    = (n_part >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_state <= F_SQ;
                        r_cnt   <= '0;
                    end
                end
                F_SQ: begin
                    if (r_cnt == CNT_W'(2)) begin
                        r_state <= F_RT;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                F_RT: begin
                    if (r_cnt == CNT_W'(S - 1)) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_smp[0] <= i_accel_x;
                    r_smp[1] <= i_accel_y;
                    r_smp[2] <= i_accel_z;
                    r_time   <= i_time_ms;
                    r_acc    <= '0;
                end
            end
            F_SQ: begin
                r_acc <= r_acc + n_sq;
                if (r_cnt == CNT_W'(2)) begin
                    r_root <= '0;
                    r_rem  <= '0;
                end
            end
            F_RT: begin
                r_acc  <= {r_acc[SQ_W-3:0], 2'b00};
                r_root <= {r_root[S-2:0], n_ge};
                r_rem  <= n_ge ? (S+1)'(n_part - n_trial) : n_part[S:0];
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/iva_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inactivity vibration alert: back end
// Moving average, motion test, stillness timer and vibration ramp; holds the
// result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module iva_back #(
    parameter int WINDOW_LEN  = iva_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = iva_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire iva_pkg::t_cfg                          i_cfg,
    input  wire logic                                   i_q_valid,
    output logic                                        o_q_pop,
    input  wire logic [iva_pkg::TIME_W+SAMPLE_BITS-1:0] i_q_data,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [iva_pkg::OUT_W-1:0]                   o_data
);
    import iva_pkg::*;

    localparam int S         = SAMPLE_BITS;
    localparam int DW        = $clog2(WINDOW_LEN);
    localparam int SUM_W     = S + DW;
    localparam int CMP_W     = ((S > 16) ? S : 16) + 1;
    localparam int AVG_SHIFT = SUM_W + DW;
    localparam int RCP_W     = SUM_W + 2;
    localparam int PRD_W     = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RECIP =
        RCP_W'(((64'd1 << AVG_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_WIN  = 3'd1;
    localparam logic [2:0] B_DIV  = 3'd2;
    localparam logic [2:0] B_CMP  = 3'd3;
    localparam logic [2:0] B_MUL  = 3'd4;
    localparam logic [2:0] B_RAMP = 3'd5;
    localparam logic [2:0] B_OUT  = 3'd6;

    logic [2:0]          r_state;
    logic [S-1:0]        r_win [WINDOW_LEN];
    logic [SUM_W-1:0]    r_sum;
    logic [DW-1:0]       r_slot;
    logic [TIME_W-1:0]   r_last_motion;
    logic [1:0]          r_phase;
    logic [TIME_W-1:0]   r_ramp_start;
    logic [S-1:0]        r_mag;
    logic [TIME_W-1:0]   r_now;
    logic [S-1:0]        r_avg;
    logic [63:0]         r_prod;
    logic [OUT_BITS-1:0] r_res;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;

    logic [SUM_W-1:0]  n_sum;
    logic [PRD_W-1:0]  n_avg_prod;
    logic [CMP_W-1:0]  n_avg;
    logic [CMP_W-1:0]  n_g;
    logic [CMP_W-1:0]  n_dev;
    logic              n_motion;
    logic              n_still;
    logic [TIME_W-1:0] n_elapsed;
    logic [28:0]       n_ticks;
    logic [7:0]        n_level;
    logic [7:0]        n_drive;
    logic [7:0]        n_span;

    assign o_q_pop = (r_state == B_IDLE) && i_q_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_comb begin
        n_sum      = r_sum - SUM_W'(r_win[r_slot]) + SUM_W'(r_mag);
        // Average by multiplication with the rounded-up reciprocal of the window
        // length; the extra fraction bits make it exact for every window sum.
        n_avg_prod = PRD_W'(r_sum) * PRD_W'(AVG_RECIP);
        n_avg      = CMP_W'(r_avg);
        n_g        = CMP_W'(i_cfg.one_g);
        n_dev      = (n_avg >= n_g) ? n_avg - n_g : n_g - n_avg;
        n_motion   = (n_dev > CMP_W'(i_cfg.motion_threshold));
        n_still    = ((r_now - r_last_motion) >= i_cfg.stationary_time_ms);
        n_elapsed  = r_now - r_ramp_start;
        n_ticks    = r_prod[63:RECIP_SHIFT];
        // Ramp offset in duty steps, held at the top once it gets there.
        n_level    = (n_ticks >= 29'(UP_TICKS)) ? RAMP_TOP
                                                 : 8'(n_ticks[5:0]) * RAMP_STEP;
        n_span     = RAMP_TOP - i_cfg.ramp_floor;
        n_drive    = RAMP_TOP - n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_sum         <= '0;
            r_slot        <= '0;
            r_last_motion <= '0;
            r_phase       <= PH_IDLE;
            r_ramp_start  <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (r_state == B_OUT && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= B_WIN;
                    end
                end
                B_WIN: begin
                    r_sum         <= n_sum;
                    r_win[r_slot] <= r_mag;
                    r_slot        <= (r_slot == DW'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                    r_state       <= B_DIV;
                end
                B_DIV: begin
                    r_state <= B_CMP;
                end
                B_CMP: begin
                    if (n_motion) begin
                        r_last_motion <= r_now;
                        r_state       <= B_OUT;
                    end else if (!n_still) begin
                        r_state <= B_OUT;
                    end else if (r_phase != PH_UP && r_phase != PH_DOWN) begin
                        // A new ramp starts at level zero.
                        r_ramp_start <= r_now;
                        r_phase      <= PH_UP;
                        r_state      <= B_OUT;
                    end else begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_state <= B_RAMP;
                end
                B_RAMP: begin
                    if (r_phase == PH_UP) begin
                        if (n_ticks >= 29'(UP_TICKS)) begin
                            // The top turns the ramp round within the same sample.
                            r_ramp_start <= r_now;
                            r_phase      <= (n_span == 8'd0) ? PH_IDLE : PH_DOWN;
                        end
                    end else if (n_level >= n_span) begin
                        r_phase <= PH_IDLE;
                    end
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    r_mag <= i_q_data[S-1:0];
                    r_now <= i_q_data[TIME_W+S-1:S];
                end
            end
            B_DIV: begin
                r_avg <= n_avg_prod[AVG_SHIFT +: S];
            end
            B_CMP: begin
                // Working result: drive level above the alerting and motion flags.
                r_res  <= {8'd0, n_still && !n_motion, n_motion};
                r_prod <= 64'(n_elapsed) * 64'(RECIP_10);
            end
            B_RAMP: begin
                if (r_phase == PH_UP) begin
                    if (n_ticks >= 29'(UP_TICKS) && n_span == 8'd0) begin
                        r_res[9:2] <= i_cfg.ramp_floor;
                    end else begin
                        r_res[9:2] <= n_level;
                    end
                end else if (n_level >= n_span) begin
                    r_res[9:2] <= i_cfg.ramp_floor;
                end else begin
                    r_res[9:2] <= n_drive;
                end
            end
            B_OUT: begin
                // The output word changes only once the previous one has gone.
                if (!r_out_valid || i_ready) begin
                    r_out_data <= {(OUT_W-OUT_BITS)'(0), r_res};
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/inactivity_vibration_alert_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Inactivity vibration alert unit
// Accelerometer magnitude, moving-average motion test and vibration ramp.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   x, y, z samples, time_ms
//  m_axis    out  m_axis_tvalid/m_axis_tready   motion_seen, alerting, drive_level
//  cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// The front end accepts a sample, forms the three squares on one multiplier,
// takes one square-root bit per cycle and queues the word; it takes no new
// sample until that word is queued. The back end steps through window, average
// by reciprocal multiplication, compare, ramp (only while a ramp runs) and
// output. Reset is synchronous and leaves the window and timers at zero. A
// stalled output holds the back end in its output state; the two-word queue
// lets the front run on.
// ----------------------------------------------------------------------------
module inactivity_vibration_alert_unit #(
    parameter int WINDOW_LEN  = iva_pkg::DEF_WINDOW_LEN,
    parameter int SAMPLE_BITS = iva_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // accel_x, accel_y, accel_z, time_ms, zero fill to whole bytes
    input  wire logic [((3*SAMPLE_BITS+iva_pkg::TIME_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // motion_seen, alerting, drive_level[7:0], six zero bits
    output logic [iva_pkg::OUT_W-1:0]  m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_idx,
    input  wire logic [31:0]           i_cfg_data
);
    import iva_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int ITEM_W = TIME_W + S;

    t_cfg              r_cfg;
    logic              n_push;
    logic [ITEM_W-1:0] n_item;
    logic              n_full;
    logic              n_pop;
    logic              n_q_valid;
    logic [ITEM_W-1:0] n_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_threshold   <= RST_MOTION_THRESHOLD;
            r_cfg.one_g              <= RST_ONE_G;
            r_cfg.stationary_time_ms <= RST_STATIONARY_TIME_MS;
            r_cfg.ramp_floor         <= RST_RAMP_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MOTION_THRESHOLD:   r_cfg.motion_threshold   <= i_cfg_data[15:0];
                REG_ONE_G:              r_cfg.one_g              <= i_cfg_data[15:0];
                REG_STATIONARY_TIME_MS: r_cfg.stationary_time_ms <= i_cfg_data;
                REG_RAMP_FLOOR:         r_cfg.ramp_floor         <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    iva_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_accel_x (s_axis_tdata[S-1:0]),
        .i_accel_y (s_axis_tdata[2*S-1:S]),
        .i_accel_z (s_axis_tdata[3*S-1:2*S]),
        .i_time_ms (s_axis_tdata[3*S+TIME_W-1:3*S]),
        .o_push    (n_push),
        .o_item    (n_item),
        .i_full    (n_full)
    );

    iva_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_data  (n_item),
        .o_full  (n_full),
        .i_pop   (n_pop),
        .o_valid (n_q_valid),
        .o_data  (n_q_data)
    );

    iva_back #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (n_q_valid),
        .o_q_pop   (n_pop),
        .i_q_data  (n_q_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule
`default_nettype wire
